FILE: design/tvf_pkg.sv
// Shared types, constants and register codes for the TSDF voxel fusion block.
package tvf_pkg;

  // Voxel store geometry (power of two; the address is taken modulo the depth)
  localparam int VOXEL_COUNT = 65536;
  localparam int IDX_W       = $clog2(VOXEL_COUNT);

  // Register reset values
  localparam logic [14:0] TRUNC_RESET   = 15'd205;
  localparam logic [14:0] EPS_RESET     = 15'd61;
  localparam logic        DROP_EN_RESET = 1'b1;
  localparam logic [15:0] MAX_W_RESET   = 16'hFFFF;

  // Iterative divider geometry: quotient always fits in DIV_Q_W bits
  localparam int DIV_Q_W   = 16;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  typedef enum logic [1:0] {
    CFG_TRUNC   = 2'd0,
    CFG_EPS     = 2'd1,
    CFG_DROP_EN = 2'd2,
    CFG_MAX_W   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [15:0]        voxel_address;
    logic [15:0]        obs_weight;
    logic signed [15:0] obs_sdf;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_address;
    logic signed [15:0] fused_distance;
    logic [15:0]        fused_weight;
    logic               was_updated;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] distance;
    logic [15:0]        weight;
  } voxel_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    voxel_t           data;
  } store_wr_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: design/tvf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by both divisions.
module tvf_div (
  input  logic               clk,
  input  logic               rst,
  input  tvf_pkg::div_req_t  req,
  output tvf_pkg::div_rsp_t  rsp
);
  import tvf_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_Q_W-1:0]   quo;
  logic [DIV_DEN_W:0]   trial_in;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;

  always_comb begin
    trial_in = {rem, quo[DIV_Q_W-1]};
    take     = trial_in >= {1'b0, den};
    trial    = trial_in - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Upper numerator bits are below the divisor, so only DIV_Q_W steps are needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[DIV_NUM_W-1:DIV_Q_W];
      quo <= req.num[DIV_Q_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= take ? trial[DIV_DEN_W-1:0] : trial_in[DIV_DEN_W-1:0];
      quo <= {quo[DIV_Q_W-2:0], take};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

FILE: design/tvf_store.sv
// Voxel store: one-port-read, one-port-write RAM with a clearing sweep after reset.
module tvf_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [tvf_pkg::IDX_W-1:0] rd_addr,
  output tvf_pkg::voxel_t           rd_data,
  input  tvf_pkg::store_wr_t        wr,
  output logic                      clearing
);
  import tvf_pkg::*;

  voxel_t           mem [VOXEL_COUNT];
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/tsdf_voxel_fusion.sv
// Top level of the TSDF voxel fusion block: control sequencer, arithmetic and ports.
// Throughput: one request at a time, through the shared 16-step divider; in_ready
//   stays low until the previous result has been handed to the output register.
// Reset: configuration and control registers take their reset values; the voxel
//   store is then cleared, one entry per cycle over all 65536 entries, with in_ready
//   held low.
module tsdf_voxel_fusion (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tvf_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tvf_pkg::out_item_t out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import tvf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_LOAD  = 11'b000_0000_0010,
    S_DIVA  = 11'b000_0000_0100,
    S_WAITA = 11'b000_0000_1000,
    S_MULS  = 11'b000_0001_0000,
    S_MULD  = 11'b000_0010_0000,
    S_SUM   = 11'b000_0100_0000,
    S_DIVB  = 11'b000_1000_0000,
    S_WAITB = 11'b001_0000_0000,
    S_CLAMP = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [14:0] trunc;
  logic [14:0] eps;
  logic        drop_en;
  logic [15:0] max_w;

  // Request payload and per-request flags
  logic [15:0]        addr;
  logic [15:0]        w;
  logic signed [15:0] s;
  logic [15:0]        tps;
  logic               kill;
  logic               use_div;

  // Stored voxel and working values
  logic signed [15:0] old_d;
  logic [15:0]        old_w;
  logic [15:0]        u;
  logic [16:0]        n;
  logic signed [33:0] prod;
  logic signed [33:0] psu;
  logic signed [33:0] sum;
  logic               neg;
  logic [15:0]        quot;
  logic signed [15:0] res_d;
  logic [15:0]        res_w;
  logic               upd;

  // Accept-time decode
  logic               accept;
  logic signed [16:0] s17;
  logic signed [16:0] eps17;
  logic signed [17:0] tps18;
  logic               drop;
  logic               tps_pos;

  // Shared multiplier
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;

  // Final arithmetic
  logic signed [33:0] mag;
  logic signed [16:0] d17;
  logic signed [16:0] t17;
  logic signed [15:0] d_clamped;
  logic [15:0]        w_sat;
  logic [15:0]        w_capped;

  // Submodule links
  voxel_t    rd_data;
  store_wr_t store_wr;
  logic      clearing;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      out_free;

  tvf_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (IDX_W'(in_data.voxel_address)),
    .rd_data  (rd_data),
    .wr       (store_wr),
    .clearing (clearing)
  );

  tvf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trunc   <= TRUNC_RESET;
      eps     <= EPS_RESET;
      drop_en <= DROP_EN_RESET;
      max_w   <= MAX_W_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TRUNC:   trunc   <= cfg_data[14:0];
        CFG_EPS:     eps     <= cfg_data[14:0];
        CFG_DROP_EN: drop_en <= cfg_data[0];
        CFG_MAX_W:   max_w   <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Dropoff (if enabled): behind the surface by more than eps, weight scales by
  // (T+s)/(T-eps); it is zero outright when T <= eps or T+s is not positive.
  always_comb begin
    s17     = {in_data.obs_sdf[15], in_data.obs_sdf};
    eps17   = {2'b00, eps};
    tps18   = {{2{in_data.obs_sdf[15]}}, in_data.obs_sdf} + {3'b000, trunc};
    drop    = drop_en && (s17 < -eps17);
    tps_pos = !tps18[17] && (tps18 != 18'sd0);
  end

  // Operand select for the one multiplier: w*(T+s), then s*u, then d*w
  always_comb begin
    mul_a = {1'b0, w};
    mul_b = {1'b0, tps};
    if (state == S_MULS) begin
      mul_a = {s[15], s};
      mul_b = {1'b0, u};
    end else if (state == S_MULD) begin
      mul_a = {old_d[15], old_d};
      mul_b = {1'b0, old_w};
    end
    mul_p = mul_a * mul_b;
  end

  // Divider requests: dropoff scale in DIVA, weighted average magnitude in DIVB
  always_comb begin
    mag           = sum[33] ? -sum : sum;
    div_req.start = (state == S_DIVA) || (state == S_DIVB);
    div_req.num   = (state == S_DIVB) ? mag[DIV_NUM_W-1:0] : prod[DIV_NUM_W-1:0];
    div_req.den   = (state == S_DIVB) ? n : {2'b00, trunc - eps};
  end

  // Restore the sign, clamp to the truncation band, saturate and cap the weight
  always_comb begin
    d17 = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    t17 = {2'b00, trunc};
    if (d17 > t17) begin
      d_clamped = t17[15:0];
    end else if (d17 < -t17) begin
      d_clamped = 16'(-t17);
    end else begin
      d_clamped = d17[15:0];
    end
    w_sat    = n[16] ? 16'hFFFF : n[15:0];
    w_capped = (w_sat > max_w) ? max_w : w_sat;
  end

  // Write back only on a real update, in the cycle the result is handed off
  always_comb begin
    store_wr.en            = (state == S_FIN) && out_free && upd;
    store_wr.addr          = IDX_W'(addr);
    store_wr.data.distance = res_d;
    store_wr.data.weight   = res_w;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_LOAD;
      S_LOAD:  state_next = use_div ? S_DIVA : S_MULS;
      S_DIVA:  state_next = S_WAITA;
      S_WAITA: if (div_rsp.done) state_next = S_MULS;
      S_MULS:  state_next = S_MULD;
      S_MULD:  state_next = S_SUM;
      S_SUM:   state_next = (n == 17'd0) ? S_FIN : S_DIVB;
      S_DIVB:  state_next = S_WAITB;
      S_WAITB: if (div_rsp.done) state_next = S_CLAMP;
      S_CLAMP: state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr    <= in_data.voxel_address;
      w       <= in_data.obs_weight;
      s       <= in_data.obs_sdf;
      tps     <= tps18[15:0];
      kill    <= drop && ((trunc <= eps) || !tps_pos);
      use_div <= drop && (trunc > eps) && tps_pos;
    end
    unique case (state)
      S_LOAD: begin
        old_d <= rd_data.distance;
        old_w <= rd_data.weight;
        prod  <= mul_p;
        u     <= kill ? 16'd0 : w;
      end
      S_WAITA: if (div_rsp.done) u <= div_rsp.quot;
      S_MULS: begin
        prod <= mul_p;
        n    <= {1'b0, old_w} + {1'b0, u};
      end
      S_MULD: begin
        psu  <= prod;
        prod <= mul_p;
      end
      S_SUM: begin
        sum   <= psu + prod;
        res_d <= old_d;
        res_w <= old_w;
        upd   <= 1'b0;
      end
      S_DIVB:  neg <= sum[33];
      S_WAITB: if (div_rsp.done) quot <= div_rsp.quot;
      S_CLAMP: begin
        res_d <= d_clamped;
        res_w <= w_capped;
        upd   <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: hold the result until taken; the input side keeps going
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      out_data.out_address    <= addr;
      out_data.fused_distance <= res_d;
      out_data.fused_weight   <= res_w;
      out_data.was_updated    <= upd;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !in_ready)
    else $error("request accepted during store clearing");

  a_write_only_at_finish: assert property (
    @(posedge clk) disable iff (rst) store_wr.en |-> (state == S_FIN) && upd)
    else $error("store written outside finish");

  a_div_done_when_waiting: assert property (
    @(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAITA) || (state == S_WAITB))
    else $error("divider result arrived with no one waiting");

  a_weight_capped: assert property (
    @(posedge clk) disable iff (rst) store_wr.en |-> store_wr.data.weight <= max_w)
    else $error("stored weight above cap");
`endif

endmodule
